FILE: rtl/core/indexed_list_buffer_defines.svh
// ----------------------------------------------------------------------------
// indexed_list_buffer_defines
// Assertion macros used by the checker of the indexed list buffer.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_BUFFER_DEFINES_SVH
`define INDEXED_LIST_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ILB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ILB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ilb_pkg.sv
// ----------------------------------------------------------------------------
// ilb_pkg
// Command, status, state and cell operation codes of the indexed list buffer.
// ----------------------------------------------------------------------------
package ilb_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_EDIT   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_READ   = 3'd4,
    CMD_FIND   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

endpackage

FILE: rtl/core/indexed_list_buffer.sv
// ----------------------------------------------------------------------------
// indexed_list_buffer
// Ordered list store of DEPTH words built as a ring of cells.
// ----------------------------------------------------------------------------
// Usage: drive cmd_i, position_in_i and value_in_i with start high; the item
// is taken at a rising edge where start is high and busy is low. Its single
// result appears for exactly one cycle with done_o high; the receiver cannot
// stall, so capture it in that cycle. Append, insert and edit, and any item
// that fails its index or capacity check, pass from accept through the apply
// state straight back to idle; the result strobe is registered from the apply
// state. Read, remove and find first scan: the entries are rotated once
// around the ring of cells, one step per cycle, past cell 0, where the index
// match or value compare is made; the rotation leaves every entry in its
// original place. Insert and remove shift the cells from the position upward
// all at once. No clearing pass after reset: entries past the count are never
// read. count_out_o, is_empty_o and is_full_o always show the current count.
// ----------------------------------------------------------------------------
module indexed_list_buffer #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        cmd_i,
  input  logic [5:0]        position_in_i,
  input  logic [31:0]       value_in_i,
  output logic              done_o,
  output logic [31:0]       value_out_o,
  output logic [5:0]        position_out_o,
  output logic              found_o,
  output ilb_pkg::status_e  status_o,
  output logic [6:0]        count_out_o,
  output logic              is_empty_o,
  output logic              is_full_o
);
  import ilb_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  // width wide enough for both the position port and the count
  localparam int POS_W = (CNT_W > 6) ? CNT_W : 6;
  localparam logic [IDX_W-1:0] LastIdx  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);

  state_e                state_q, state_d;
  cmd_e                  cmd_q;
  status_e               status_q;
  logic [IDX_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] key_q;
  logic [IDX_W-1:0]      scan_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_pos_q;
  logic [DATA_WIDTH-1:0] rd_val_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q;

  logic                  accept;
  cmd_e                  cmd_in;
  status_e               status_d;
  logic                  need_scan;
  logic [IDX_W-1:0]      pos_d;
  logic [POS_W-1:0]      pos_w;
  logic [POS_W-1:0]      cnt_w;
  logic                  store_full;

  cell_op_e              cell_op;
  logic [DATA_WIDTH-1:0] cell_val [DEPTH];
  logic [DATA_WIDTH-1:0] head;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign cmd_in = cmd_e'(cmd_i);
  assign pos_w  = POS_W'(position_in_i);
  assign cnt_w  = POS_W'(count_q);
  assign store_full = (count_q == DepthCnt);
  assign head   = cell_val[0];

  // Check the item against the current count at accept time.
  always_comb begin
    status_d  = STAT_OK;
    need_scan = 1'b0;
    pos_d     = IDX_W'(position_in_i);
    unique case (cmd_in)
      CMD_APPEND: begin
        pos_d = IDX_W'(count_q);
        if (store_full) status_d = STAT_FULL;
      end
      CMD_INSERT: begin
        if (pos_w > cnt_w) status_d = STAT_BAD_INDEX;
        else if (store_full) status_d = STAT_FULL;
      end
      CMD_EDIT: begin
        if (pos_w >= cnt_w) status_d = STAT_BAD_INDEX;
      end
      CMD_REMOVE, CMD_READ: begin
        if (pos_w >= cnt_w) status_d = STAT_BAD_INDEX;
        else need_scan = 1'b1;
      end
      CMD_FIND:   need_scan = 1'b1;
      default:    status_d  = STAT_OK; // unused codes do nothing
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = need_scan ? S_SCAN : S_APPLY;
      end
      S_SCAN: begin
        if (scan_q == LastIdx) state_d = S_APPLY;
      end
      S_APPLY:  state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Cell control and count update.
  always_comb begin
    cell_op = OP_HOLD;
    count_d = count_q;
    unique case (state_q)
      S_SCAN:  cell_op = OP_ROTATE;
      S_APPLY: begin
        if (status_q == STAT_OK) begin
          unique case (cmd_q)
            CMD_APPEND: begin
              cell_op = OP_WRITE;
              count_d = count_q + CNT_W'(1);
            end
            CMD_INSERT: begin
              cell_op = OP_INSERT;
              count_d = count_q + CNT_W'(1);
            end
            CMD_EDIT:   cell_op = OP_WRITE;
            CMD_REMOVE: begin
              cell_op = OP_REMOVE;
              count_d = count_q - CNT_W'(1);
            end
            default:    cell_op = OP_HOLD;
          endcase
        end
      end
      default: cell_op = OP_HOLD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      cmd_q    <= CMD_APPEND;
      status_q <= STAT_OK;
      scan_q   <= '0;
      hit_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= (state_q == S_APPLY);
      if (accept) begin
        cmd_q    <= cmd_in;
        status_q <= status_d;
        scan_q   <= '0;
        hit_q    <= 1'b0;
      end else if (state_q == S_SCAN) begin
        scan_q <= scan_q + IDX_W'(1);
        // first live entry equal to the key wins
        if (cmd_q == CMD_FIND && !hit_q && CNT_W'(scan_q) < count_q && head == key_q) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // Item payload and scan results.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q     <= pos_d;
      key_q     <= DATA_WIDTH'(value_in_i);
      hit_pos_q <= '0;
      rd_val_q  <= '0;
    end else if (state_q == S_SCAN) begin
      if ((cmd_q == CMD_READ || cmd_q == CMD_REMOVE) && scan_q == pos_q) begin
        rd_val_q <= head;
      end
      if (cmd_q == CMD_FIND && !hit_q && CNT_W'(scan_q) < count_q && head == key_q) begin
        hit_pos_q <= scan_q;
      end
    end
  end

  // Ring of cells: cell i sees cell i-1 below and cell i+1 above, wrapping.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int Prev = (i + DEPTH - 1) % DEPTH;
    localparam int Next = (i + 1) % DEPTH;
    ilb_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .pos_i   (pos_q),
      .data_i  (key_q),
      .prev_i  (cell_val[Prev]),
      .next_i  (cell_val[Next]),
      .value_o (cell_val[i])
    );
  end

  assign done_o         = done_q;
  assign value_out_o    = 32'(rd_val_q);
  assign position_out_o = 6'(hit_pos_q);
  assign found_o        = hit_q;
  assign status_o       = status_q;
  assign count_out_o    = 7'(count_q);
  assign is_empty_o     = (count_q == '0);
  assign is_full_o      = store_full;

endmodule

FILE: rtl/core/ilb_cell.sv
// ----------------------------------------------------------------------------
// ilb_cell
// One entry of the list ring: holds, rotates, writes or shifts its word.
// ----------------------------------------------------------------------------
module ilb_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 6,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  ilb_pkg::cell_op_e     op_i,
  input  logic [IDX_W-1:0]      pos_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] value_o
);
  import ilb_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    unique case (op_i)
      OP_HOLD:   value_d = value_q;
      OP_ROTATE: value_d = next_i;
      OP_WRITE: begin
        if (MyIdx == pos_i) value_d = data_i;
      end
      OP_INSERT: begin
        // take the lower neighbor above the slot, the new word at it
        if (MyIdx > pos_i) value_d = prev_i;
        else if (MyIdx == pos_i) value_d = data_i;
      end
      OP_REMOVE: begin
        if (MyIdx >= pos_i) value_d = next_i;
      end
      default:   value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: rtl/core/ilb_checker.sv
// ----------------------------------------------------------------------------
// ilb_checker
// Port-level checks of the indexed list buffer, bound to its top level.
// ----------------------------------------------------------------------------
`include "indexed_list_buffer_defines.svh"

module ilb_checker #(
  parameter int DEPTH = 64
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [31:0]      value_out_o,
  input logic             found_o,
  input ilb_pkg::status_e status_o,
  input logic [6:0]       count_out_o,
  input logic             is_empty_o,
  input logic             is_full_o
);
  import ilb_pkg::*;

  logic unused_depth;
  assign unused_depth = (DEPTH > 0);

  `ILB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `ILB_ASSERT_NEXT(a_single_strobe, done_o, !done_o, "result strobe held for two cycles")
  `ILB_ASSERT_NOW(a_fail_clean, done_o && status_o != STAT_OK, value_out_o == 32'd0 && !found_o, "failed item returned data")
  `ILB_ASSERT_NOW(a_empty_flags, is_empty_o && unused_depth, count_out_o == 7'd0 && !is_full_o, "empty flag disagrees with count")

endmodule

bind indexed_list_buffer ilb_checker #(.DEPTH(DEPTH)) u_ilb_checker (.*);

FILE: tb/sv/indexed_list_buffer_test.sv
// ----------------------------------------------------------------------------
// indexed_list_buffer_test
// Self-checking bench for the indexed list buffer. A short table of directed
// commands covers the empty and full corners, bad indexes and the spare
// command codes. A long random run follows, biased in phases to grow, drain,
// mix or query the list. A shadow list or a typed table row predicts each
// result, and each strobed one is checked field by field against the oldest.
// ----------------------------------------------------------------------------
module indexed_list_buffer_test;
  import ilb_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STALL_LIMIT  = 2000;

  // Codes six and seven have no member in cmd_e; the block ignores them.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int BIAS_GROW  = 0;
  localparam int BIAS_DRAIN = 1;
  localparam int BIAS_MIXED = 2;
  localparam int BIAS_QUERY = 3;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  position;
    logic        found;
    status_e     status;
    logic [6:0]  count;
    logic        empty;
    logic        full;
  } list_result_t;

  typedef struct {
    logic [2:0]   cmd;
    logic [5:0]   pos;
    logic [31:0]  val;
    int           reps;
    bit           typed;
    list_result_t want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  cmd_i;
  logic [5:0]  position_in_i;
  logic [31:0] value_in_i;
  logic        done_o;
  logic [31:0] value_out_o;
  logic [5:0]  position_out_o;
  logic        found_o;
  status_e     status_o;
  logic [6:0]  count_out_o;
  logic        is_empty_o;
  logic        is_full_o;

  // Shadow copy of the list, updated when an item is accepted.
  logic [31:0] shadow_words [LIST_DEPTH];
  int          shadow_len;

  list_result_t list_replies_due [$];
  plan_row_t    plan [$];

  // Typed expectation for the item currently presented, if any.
  bit           row_typed;
  list_result_t row_want;

  int mismatch_count;
  int stall_cycles;
  int bias;
  bit idle_on;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  indexed_list_buffer #(
    .DEPTH     (LIST_DEPTH),
    .DATA_WIDTH(32)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .position_in_i (position_in_i),
    .value_in_i    (value_in_i),
    .done_o        (done_o),
    .value_out_o   (value_out_o),
    .position_out_o(position_out_o),
    .found_o       (found_o),
    .status_o      (status_o),
    .count_out_o   (count_out_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  // Apply one command to the shadow list and return the result it causes.
  function automatic list_result_t apply_list_cmd(input logic [2:0] c, input logic [5:0] p,
                                                  input logic [31:0] v);
    list_result_t r;
    int i;
    r = '0;
    r.status = STAT_OK;
    case (c)
      CMD_APPEND: begin
        if (shadow_len >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_words[shadow_len] = v;
          shadow_len++;
        end
      end
      CMD_INSERT: begin
        // Index check wins over the full check.
        if (int'(p) > shadow_len) begin
          r.status = STAT_BAD_INDEX;
        end else if (shadow_len >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          for (i = shadow_len; i > int'(p); i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[p] = v;
          shadow_len++;
        end
      end
      CMD_EDIT: begin
        if (int'(p) >= shadow_len) r.status = STAT_BAD_INDEX;
        else shadow_words[p] = v;
      end
      CMD_REMOVE: begin
        if (int'(p) >= shadow_len) begin
          r.status = STAT_BAD_INDEX;
        end else begin
          r.value = shadow_words[p];
          for (i = int'(p); i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_len--;
        end
      end
      CMD_READ: begin
        if (int'(p) >= shadow_len) r.status = STAT_BAD_INDEX;
        else r.value = shadow_words[p];
      end
      CMD_FIND: begin
        // Stop at the lowest matching index.
        for (i = 0; i < shadow_len && !r.found; i++) begin
          if (shadow_words[i] == v) begin
            r.found    = 1'b1;
            r.position = i[5:0];
          end
        end
      end
      default: begin
      end
    endcase
    r.count = shadow_len[6:0];
    r.empty = (shadow_len == 0);
    r.full  = (shadow_len >= LIST_DEPTH);
    return r;
  endfunction

  function automatic list_result_t plain_result(input status_e s, input int n);
    list_result_t r;
    r = '0;
    r.status = s;
    r.count  = n[6:0];
    r.empty  = (n == 0);
    r.full   = (n >= LIST_DEPTH);
    return r;
  endfunction

  task automatic add_row(input logic [2:0] c, input logic [5:0] p, input logic [31:0] v,
                         input int reps, input bit typed, input status_e s, input int n);
    plan_row_t row;
    row.cmd   = c;
    row.pos   = p;
    row.val   = v;
    row.reps  = reps;
    row.typed = typed;
    row.want  = plain_result(s, n);
    plan.push_back(row);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Mostly back to back, sometimes a short gap, rarely a long one; no gaps while idling is off.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [2:0] pick_cmd();
    int roll;
    int w_app, w_ins, w_edit, w_rem, w_read;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_GROW:  begin w_app = 35; w_ins = 30; w_edit = 5;  w_rem = 10; w_read = 10; end
      BIAS_DRAIN: begin w_app = 8;  w_ins = 7;  w_edit = 10; w_rem = 40; w_read = 15; end
      BIAS_MIXED: begin w_app = 18; w_ins = 17; w_edit = 12; w_rem = 22; w_read = 13; end
      default:    begin w_app = 8;  w_ins = 8;  w_edit = 10; w_rem = 10; w_read = 30; end
    endcase
    if (roll >= 98) return ($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
    if (roll < w_app) return CMD_APPEND;
    roll -= w_app;
    if (roll < w_ins) return CMD_INSERT;
    roll -= w_ins;
    if (roll < w_edit) return CMD_EDIT;
    roll -= w_edit;
    if (roll < w_rem) return CMD_REMOVE;
    roll -= w_rem;
    if (roll < w_read) return CMD_READ;
    return CMD_FIND;
  endfunction

  // Mostly valid indexes; now and then any index at all.
  function automatic logic [5:0] pick_pos(input logic [2:0] c);
    int top;
    if ($urandom_range(0, 99) < 12) return 6'($urandom_range(0, 63));
    if (c == CMD_INSERT) begin
      top = (shadow_len > 63) ? 63 : shadow_len;
      return 6'($urandom_range(0, top));
    end
    if (shadow_len == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, shadow_len - 1));
  endfunction

  // Favor values already held so that find hits, and a small pool for repeats.
  function automatic logic [31:0] pick_value(input logic [2:0] c);
    int roll;
    if (c == CMD_FIND && shadow_len > 0 && $urandom_range(0, 2) != 0)
      return shadow_words[$urandom_range(0, shadow_len - 1)];
    roll = $urandom_range(0, 9);
    if (roll == 0) return 32'h0000_0000;
    if (roll == 1) return 32'hFFFF_FFFF;
    if (roll < 4) return 32'($urandom_range(0, 7));
    return $urandom;
  endfunction

  // Present one item at a falling edge and hold it until the block takes it.
  // Draw random fields only after the falling edge, when the shadow list has
  // settled from the previous accept.
  task automatic send_item(input bit draw, input plan_row_t row);
    int gap;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (draw) begin
      row.cmd   = pick_cmd();
      row.pos   = pick_pos(row.cmd);
      row.val   = pick_value(row.cmd);
      row.typed = 1'b0;
    end
    start         <= 1'b1;
    cmd_i         <= row.cmd;
    position_in_i <= row.pos;
    value_in_i    <= row.val;
    row_typed = row.typed;
    row_want  = row.want;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // Hold off the sender until every pending result has come back.
  task automatic drain_pause();
    @(negedge clk_i);
    start <= 1'b0;
    while (list_replies_due.size() != 0) @(negedge clk_i);
  endtask

  // Check results first, then predict the item taken at the same edge: a
  // result strobed here belongs to an earlier item.
  always @(posedge clk_i) begin : reply_monitor
    list_result_t want;
    list_result_t calc;
    bit moved;
    moved = 1'b0;
    if (rst_ni === 1'b1) begin
      if (done_o === 1'b1) begin
        moved = 1'b1;
        if (list_replies_due.size() == 0) begin
          report_mismatch("result strobed with no item pending");
        end else begin
          want = list_replies_due.pop_front();
          if (value_out_o !== want.value)
            report_mismatch($sformatf("value_out got %h want %h", value_out_o, want.value));
          if (position_out_o !== want.position)
            report_mismatch($sformatf("position_out got %0d want %0d", position_out_o,
                                      want.position));
          if (found_o !== want.found)
            report_mismatch($sformatf("found got %b want %b", found_o, want.found));
          if (status_o !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
          if (count_out_o !== want.count)
            report_mismatch($sformatf("count_out got %0d want %0d", count_out_o, want.count));
          if (is_empty_o !== want.empty)
            report_mismatch($sformatf("is_empty got %b want %b", is_empty_o, want.empty));
          if (is_full_o !== want.full)
            report_mismatch($sformatf("is_full got %b want %b", is_full_o, want.full));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        moved = 1'b1;
        // Run the predictor on every item so the shadow list stays in step.
        calc = apply_list_cmd(cmd_i, position_in_i, value_in_i);
        list_replies_due.push_back(row_typed ? row_want : calc);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // End the run if no handshake of either kind happens for too long.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(negedge clk_i);
    $display("[%0t] watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    plan_row_t row;
    int n;
    start         <= 1'b0;
    cmd_i         <= CMD_APPEND;
    position_in_i <= '0;
    value_in_i    <= '0;
    rst_ni        <= 1'b0;
    row_typed      = 1'b0;
    row_want       = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    shadow_len     = 0;
    bias           = BIAS_GROW;
    idle_on        = 1'b1;

    // Empty list: every indexed access is out of range, find misses.
    add_row(CMD_READ,    6'd0,  32'h0000_0000, 1, 1, STAT_BAD_INDEX, 0);
    add_row(CMD_REMOVE,  6'd63, 32'hFFFF_FFFF, 1, 1, STAT_BAD_INDEX, 0);
    add_row(CMD_FIND,    6'd0,  32'h0000_0000, 1, 1, STAT_OK, 0);
    add_row(CMD_INSERT,  6'd1,  32'hFFFF_FFFF, 1, 1, STAT_BAD_INDEX, 0);
    add_row(CMD_EDIT,    6'd0,  32'h0000_1234, 1, 1, STAT_BAD_INDEX, 0);
    // Build a short list with extreme values, insert at the front and the end.
    add_row(CMD_APPEND,  6'd0,  32'hFFFF_FFFF, 1, 1, STAT_OK, 1);
    add_row(CMD_APPEND,  6'd63, 32'h0000_0000, 1, 1, STAT_OK, 2);
    add_row(CMD_INSERT,  6'd0,  32'hA5A5_A5A5, 1, 1, STAT_OK, 3);
    add_row(CMD_INSERT,  6'd3,  32'h5A5A_5A5A, 1, 1, STAT_OK, 4);
    add_row(CMD_INSERT,  6'd5,  32'h0000_0000, 1, 1, STAT_BAD_INDEX, 4);
    add_row(CMD_READ,    6'd0,  32'h0000_0000, 1, 0, STAT_OK, 0);
    add_row(CMD_FIND,    6'd0,  32'h0000_0000, 1, 0, STAT_OK, 0);
    add_row(CMD_EDIT,    6'd1,  32'h1234_5678, 1, 0, STAT_OK, 0);
    add_row(CMD_EDIT,    6'd4,  32'h0000_0000, 1, 1, STAT_BAD_INDEX, 4);
    add_row(CMD_REMOVE,  6'd0,  32'h0000_0000, 1, 0, STAT_OK, 0);
    // Spare codes leave the list alone.
    add_row(CMD_SPARE_6, 6'd63, 32'hFFFF_FFFF, 1, 1, STAT_OK, 3);
    add_row(CMD_SPARE_7, 6'd0,  32'h0000_0000, 1, 1, STAT_OK, 3);
    add_row(CMD_FIND,    6'd0,  32'hDEAD_BEEF, 1, 0, STAT_OK, 0);
    // Fill to capacity, then hit the full store from both append and insert.
    add_row(CMD_APPEND,  6'd0,  32'h0F0F_0F0F, LIST_DEPTH - 3, 0, STAT_OK, 0);
    add_row(CMD_APPEND,  6'd0,  32'h0000_0000, 1, 1, STAT_FULL, LIST_DEPTH);
    add_row(CMD_INSERT,  6'd0,  32'h0000_0000, 1, 1, STAT_FULL, LIST_DEPTH);
    add_row(CMD_INSERT,  6'd63, 32'hFFFF_FFFF, 1, 1, STAT_FULL, LIST_DEPTH);
    add_row(CMD_READ,    6'd63, 32'h0000_0000, 1, 0, STAT_OK, 0);
    add_row(CMD_FIND,    6'd0,  32'h0F0F_0F0F, 1, 0, STAT_OK, 0);
    add_row(CMD_EDIT,    6'd63, 32'hFFFF_FFFF, 1, 0, STAT_OK, 0);
    add_row(CMD_REMOVE,  6'd63, 32'h0000_0000, 1, 0, STAT_OK, 0);
    add_row(CMD_REMOVE,  6'd0,  32'h0000_0000, 1, 0, STAT_OK, 0);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) begin
      for (n = 0; n < plan[k].reps; n++) send_item(1'b0, plan[k]);
    end

    // Random run: switch bias and idling every phase, drain now and then.
    row = plan[0];
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        bias    = $urandom_range(BIAS_GROW, BIAS_QUERY);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (n % 400 == 200) drain_pause();
      send_item(1'b1, row);
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (list_replies_due.size() != 0) @(posedge clk_i);
    // Give a stray result time to show up.
    repeat (LIST_DEPTH + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ilb_pkg.sv
rtl/core/ilb_cell.sv
rtl/core/indexed_list_buffer.sv
rtl/core/ilb_checker.sv
tb/sv/indexed_list_buffer_test.sv
